/* hdl/trcm_pkg.sv */
// Shared types and constants for the touch report coordinate mapper.
// No dependencies.
`timescale 1ns / 1ps
package trcm_pkg;
    localparam int COORD_W = 12;
    localparam int PROD_W  = 24;
    localparam logic [COORD_W-1:0] COORD_MAX = 12'hFFF;

    typedef enum logic [2:0] {
        REG_DISPLAY_WIDTH  = 3'd0,
        REG_DISPLAY_HEIGHT = 3'd1,
        REG_PANEL_X_RES    = 3'd2,
        REG_PANEL_Y_RES    = 3'd3,
        REG_ROTATION       = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    // One job for the back end: one point or one release.
    typedef struct packed {
        logic               release_evt;
        logic               last;
        logic [COORD_W-1:0] raw_x;
        logic [COORD_W-1:0] raw_y;
    } t_job;

    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [COORD_W-1:0] xres;
        logic [COORD_W-1:0] yres;
        logic [1:0]         rot;
    } t_cfg;

    function automatic logic [COORD_W-1:0] mirror(input logic [COORD_W-1:0] dim,
                                                  input logic [COORD_W-1:0] q);
        logic [COORD_W-1:0] top;
        top = (dim != '0) ? dim - 1'b1 : '0;
        return (q > top) ? '0 : top - q;
    endfunction
endpackage

/* hdl/trcm_front.sv */
// Front end: accepts reports, counts fingers and pushes point or release
// jobs into a two-entry queue. Depends on trcm_pkg.
`timescale 1ns / 1ps
module trcm_front import trcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);
    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       r_busy;     // second point of a report still to push
    t_job       r_pend;

    logic [3:0] pop;
    logic [7:0] mask;
    t_job       j0, j1, push_job;
    logic       push, pull, multi;

    always_comb begin
        mask = s_axis_tdata[55:48];
        pop  = '0;
        for (int i = 0; i < 8; i++) pop = pop + {3'b0, mask[i]};
        multi = (pop > 4'd1);
        j0.release_evt = (pop == 4'd0);
        j0.last        = !multi;
        j0.raw_x       = (pop == 4'd0) ? '0 : {s_axis_tdata[7:4], s_axis_tdata[15:8]};
        j0.raw_y       = (pop == 4'd0) ? '0 : {s_axis_tdata[3:0], s_axis_tdata[23:16]};
        j1.release_evt = 1'b0;
        j1.last        = 1'b1;
        j1.raw_x       = {s_axis_tdata[31:28], s_axis_tdata[39:32]};
        j1.raw_y       = {s_axis_tdata[27:24], s_axis_tdata[47:40]};
    end

    assign s_axis_tready = !r_busy && (r_cnt != 2'd2);
    assign push     = r_busy ? (r_cnt != 2'd2) : (s_axis_tvalid && s_axis_tready);
    assign push_job = r_busy ? r_pend : j0;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign pull        = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_busy <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_wp] <= push_job;
                r_wp      <= !r_wp;
            end
            if (pull) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pull};
            if (r_busy && push) r_busy <= 1'b0;
            else if (!r_busy && push && multi) begin
                r_busy <= 1'b1;
                r_pend <= j1;
            end
        end
    end
endmodule

/* hdl/trcm_div.sv */
// Sequential 24 by 12 bit restoring divider, one quotient bit a cycle,
// saturating to 4095. Depends on trcm_pkg.
`timescale 1ns / 1ps
module trcm_div import trcm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PROD_W-1:0]  i_num,
    input  logic [COORD_W-1:0] i_den,
    output logic               o_done,
    output logic [COORD_W-1:0] o_quo
);
    logic [PROD_W-1:0]  r_q;
    logic [COORD_W:0]   r_rem;
    logic [COORD_W-1:0] r_den;
    logic [4:0]         r_n;
    logic               r_run;
    logic [COORD_W:0]   sh;
    logic [COORD_W:0]   df;

    always_comb begin
        sh = {r_rem[COORD_W-1:0], r_q[PROD_W-1]};
        df = sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; o_done <= 1'b0;
        end else begin
            o_done <= !i_start && r_run && (r_n == 5'd1);
            if (i_start) begin
                r_q <= i_num; r_rem <= '0; r_den <= i_den;
                r_n <= 5'(PROD_W); r_run <= 1'b1;
            end else if (r_run) begin
                if (!df[COORD_W]) begin
                    r_rem <= df;
                    r_q   <= {r_q[PROD_W-2:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_q   <= {r_q[PROD_W-2:0], 1'b0};
                end
                r_n <= r_n - 1'b1;
                if (r_n == 5'd1) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    assign o_quo = (r_den == '0 || r_q[PROD_W-1:COORD_W] != '0) ? COORD_MAX
                                                               : r_q[COORD_W-1:0];
endmodule

/* hdl/trcm_back.sv */
// Back end: scales one job with two dividers, applies the rotation and
// holds the result word for the output. Depends on trcm_pkg, trcm_div.
`timescale 1ns / 1ps
module trcm_back import trcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tuser
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} t_state;
    t_state r_st;
    t_job   r_job;
    logic [PROD_W-1:0] r_px, r_py;
    logic   r_start;
    logic   dx_done, dy_done;
    logic [COORD_W-1:0] qx, qy, sx, sy;
    logic   r_oval, r_olast, r_orel;
    logic [COORD_W-1:0] r_ox, r_oy;
    logic [PROD_W-1:0] mx, my;
    logic   out_ld;

    assign mx = PROD_W'(r_job.raw_x) * PROD_W'(i_cfg.height);
    assign my = PROD_W'(r_job.raw_y) * PROD_W'(i_cfg.width);

    trcm_div u_dx (.i_clk, .i_rst_n, .i_start(r_start), .i_num(r_px),
                   .i_den(i_cfg.xres), .o_done(dx_done), .o_quo(qx));
    trcm_div u_dy (.i_clk, .i_rst_n, .i_start(r_start), .i_num(r_py),
                   .i_den(i_cfg.yres), .o_done(dy_done), .o_quo(qy));

    always_comb begin
        case (t_rot'(i_cfg.rot))
            ROT_0:   begin sx = mirror(i_cfg.width, qy);  sy = qx; end
            ROT_90:  begin sx = qx; sy = qy; end
            ROT_180: begin sx = qy; sy = mirror(i_cfg.height, qx); end
            ROT_270: begin sx = mirror(i_cfg.height, qx); sy = mirror(i_cfg.width, qy); end
            default: begin sx = qx; sy = qy; end
        endcase
    end

    assign o_job_ready   = (r_st == S_IDLE);
    assign out_ld        = (r_st == S_OUT) && (!r_oval || m_axis_tready);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {r_oy, r_ox};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_orel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_start <= 1'b0; r_oval <= 1'b0;
        end else begin
            r_start <= (r_st == S_MUL) && !r_job.release_evt;
            if (out_ld) r_oval <= 1'b1;
            else if (m_axis_tready) r_oval <= 1'b0;
            case (r_st)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_st  <= S_MUL;
                end
                S_MUL: begin
                    r_px <= (mx != '0) ? mx - 1'b1 : '0;
                    r_py <= (my != '0) ? my - 1'b1 : '0;
                    r_st <= r_job.release_evt ? S_OUT : S_DIV;
                end
                S_DIV: if (dx_done && dy_done) r_st <= S_OUT;
                S_OUT: if (out_ld) begin
                    r_olast <= r_job.last;
                    r_orel  <= r_job.release_evt;
                    r_ox    <= r_job.release_evt ? '0 : sx;
                    r_oy    <= r_job.release_evt ? '0 : sy;
                    r_st    <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

/* hdl/touch_report_coordinate_mapper.sv */
// Top level of the touch report coordinate mapper: config registers,
// front end queue and back end. Depends on trcm_pkg, trcm_front, trcm_back.
//
// Input stream s_axis: one report word per handshake. Output stream m_axis:
// one word per touch point (up to two) or a single release word, tlast on the
// final word of a report. Config channel writes register i_cfg_idx.
// Each point passes through the back end as job load, product, divider
// start, the 24-step divider pair, done and output; a release word skips
// the divider.
// A two-entry job queue lets the front end take the next report while the
// back end works, and the output register holds a word while the receiver
// stalls; the back end then waits and the queue fills before tready drops.
// Reset (synchronous, active low) empties queue and output and restores
// width 320, height 240, resolutions 4095 and rotation 0.
// Config may only be written while no report is in flight.
// The back end takes a new job only after loading the last word for output.
`timescale 1ns / 1ps
module touch_report_coordinate_mapper import trcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot0_high_nibbles, slot0_x_low, slot0_y_low, slot1_high_nibbles,
    // slot1_x_low, slot1_y_low, finger_mask
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // screen_x, screen_y
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // is_release
    output logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data
);
    t_cfg r_cfg;
    logic jv, jr;
    t_job job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{width: 12'd320, height: 12'd240, xres: 12'd4095,
                       yres: 12'd4095, rot: 2'd0};
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DISPLAY_WIDTH:  r_cfg.width  <= i_cfg_data;
                REG_DISPLAY_HEIGHT: r_cfg.height <= i_cfg_data;
                REG_PANEL_X_RES:    r_cfg.xres   <= i_cfg_data;
                REG_PANEL_Y_RES:    r_cfg.yres   <= i_cfg_data;
                REG_ROTATION:       r_cfg.rot    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    trcm_front u_front (.i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
                        .s_axis_tdata, .o_job_valid(jv), .i_job_ready(jr),
                        .o_job(job));

    trcm_back u_back (.i_clk, .i_rst_n, .i_cfg(r_cfg), .i_job_valid(jv),
                      .o_job_ready(jr), .i_job(job), .m_axis_tvalid,
                      .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
                      .m_axis_tuser);
endmodule

/* dv/testbench.sv */
// Testbench for touch_report_coordinate_mapper: sends touch reports, predicts the
// mapped points or release word for each, and checks the output stream in order.
// Depends on trcm_pkg and the mapper RTL.
`timescale 1ns / 1ps
module testbench;
    import trcm_pkg::*;

    typedef struct {
        logic        is_release;
        logic [11:0] sx;
        logic [11:0] sy;
        logic        last;
    } t_point;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_idx;
    logic [11:0] i_cfg_data;

    logic [11:0] disp_w, disp_h, xres, yres;
    logic [1:0]  rot;
    t_point      pending_points[$];
    int          errors;
    int          cycles;
    int          burst_left;
    bit          rx_quiet;

    touch_report_coordinate_mapper uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [11:0] scale(logic [11:0] raw, logic [11:0] dim,
                                          logic [11:0] res);
        logic [23:0] p;
        logic [23:0] q;
        p = raw * dim;
        if (p != 0) p = p - 24'd1;
        if (res == 0) return 12'hFFF;
        q = p / res;
        return (q > 24'hFFF) ? 12'hFFF : q[11:0];
    endfunction

    function automatic logic [11:0] flip(logic [11:0] dim, logic [11:0] q);
        logic [11:0] top;
        top = (dim != 0) ? dim - 12'd1 : 12'd0;
        return (q > top) ? 12'd0 : top - q;
    endfunction

    task automatic predict_report(logic [55:0] rep);
        int     n;
        t_point pt;
        logic [7:0]  hi, xl, yl;
        logic [11:0] qx, qy;
        n = $countones(rep[55:48]);
        if (n == 0) begin
            pt = '{1'b1, 12'd0, 12'd0, 1'b1};
            pending_points.push_back(pt);
            return;
        end
        if (n > 2) n = 2;
        for (int i = 0; i < n; i++) begin
            hi = rep[i*24 +: 8];
            xl = rep[i*24+8 +: 8];
            yl = rep[i*24+16 +: 8];
            qx = scale({hi[7:4], xl}, disp_h, xres);
            qy = scale({hi[3:0], yl}, disp_w, yres);
            pt.is_release = 1'b0;
            pt.last = (i + 1 == n);
            case (t_rot'(rot))
                ROT_0:   begin pt.sx = flip(disp_w, qy); pt.sy = qx; end
                ROT_90:  begin pt.sx = qx; pt.sy = qy; end
                ROT_180: begin pt.sx = qy; pt.sy = flip(disp_h, qx); end
                default: begin pt.sx = flip(disp_h, qx); pt.sy = flip(disp_w, qy); end
            endcase
            pending_points.push_back(pt);
        end
    endtask

    // receiver: stall pattern plus checker
    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected word %h", m_axis_tdata);
                errors++;
            end else begin
                e = pending_points.pop_front();
                if (m_axis_tuser !== e.is_release) begin
                    $error("is_release exp %0d got %0d", e.is_release, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[11:0] !== e.sx) begin
                    $error("screen_x exp %0d got %0d", e.sx, m_axis_tdata[11:0]);
                    errors++;
                end
                if (m_axis_tdata[23:12] !== e.sy) begin
                    $error("screen_y exp %0d got %0d", e.sy, m_axis_tdata[23:12]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_of_report exp %0d got %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_quiet || cycles[9:8] == 2'b01)
            m_axis_tready <= 1'b1;
        else if (cycles[9:8] == 2'b10)
            m_axis_tready <= ($urandom_range(0, 9) != 0);
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_report(logic [55:0] rep);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 40)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tdata  = rep;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_report(rep);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain;
        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [11:0] val);
        i_cfg_idx   = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_DISPLAY_WIDTH:  disp_w = val;
            REG_DISPLAY_HEIGHT: disp_h = val;
            REG_PANEL_X_RES:    xres = val;
            REG_PANEL_Y_RES:    yres = val;
            REG_ROTATION:       rot = val[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(logic [11:0] w, logic [11:0] h, logic [11:0] xr,
                              logic [11:0] yr, logic [1:0] r);
        drain();
        write_reg(REG_DISPLAY_WIDTH, w);
        write_reg(REG_DISPLAY_HEIGHT, h);
        write_reg(REG_PANEL_X_RES, xr);
        write_reg(REG_PANEL_Y_RES, yr);
        write_reg(REG_ROTATION, {10'd0, r});
    endtask

    function automatic logic [55:0] rand_report(logic [7:0] mask);
        return {mask, 24'($urandom()), 24'($urandom())};
    endfunction

    task automatic test_directed;
        logic [1:0] r;
        for (int k = 0; k < 4; k++) begin
            r = 2'(k);
            set_config(12'd320, 12'd240, 12'd4095, 12'd4095, r);
            send_report({8'h00, 48'hFFFFFF_FFFFFF});
            send_report({8'h01, 48'h000000_000000});
            send_report({8'h03, 48'hFFFFFF_FFFFFF});
            send_report({8'hFF, 48'h123456_FFFFFF});
            send_report({8'h80, 48'h000000_010100});
        end
        // tiny resolution saturates quotient, tiny display floors mirror
        set_config(12'd4095, 12'd4095, 12'd1, 12'd1, 2'd3);
        send_report({8'h03, 48'h000000_FFFFFF});
        set_config(12'd1, 12'd1, 12'd4095, 12'd4095, 2'd0);
        send_report({8'h03, 48'h010101_FFFFFF});
    endtask

    task automatic test_random;
        logic [7:0] mask;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0)
                set_config(12'd320, 12'd240, 12'd4095, 12'd4095, 2'd0);
            else if (phase == 1)
                set_config(12'd4095, 12'd4095, 12'd4095, 12'd4095, 2'd1);
            else if (phase == 2)
                set_config(12'd1, 12'd1, 12'd1, 12'd1, 2'd2);
            else
                set_config(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                           12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                           2'($urandom_range(0, 3)));
            rx_quiet = (phase == 4);
            for (int n = 0; n < 210; n++) begin
                case ($urandom_range(0, 3))
                    0: mask = 8'h00;
                    1: mask = 8'h01 << $urandom_range(0, 7);
                    default: mask = 8'($urandom());
                endcase
                send_report(rand_report(mask));
            end
            rx_quiet = 1'b0;
        end
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        burst_left = 0;
        rx_quiet = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_idx = REG_DISPLAY_WIDTH;
        i_cfg_data = '0;
        disp_w = 12'd320;
        disp_h = 12'd240;
        xres = 12'd4095;
        yres = 12'd4095;
        rot = 2'd0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_report({8'h03, 48'h0A0B0C_7F8081});
        test_directed();
        test_random();
        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* filelist.f */
hdl/trcm_pkg.sv
hdl/trcm_front.sv
hdl/trcm_div.sv
hdl/trcm_back.sv
hdl/touch_report_coordinate_mapper.sv
dv/testbench.sv
